// ===== src/cbsm_pkg.sv =====
// shared types and constants of the cartridge bank switch mapper
`default_nettype none

package cbsm_pkg;

    localparam int BANK_BYTES = 4096;
    localparam int RAM_BYTES  = 128;
    localparam int OFFSET_W   = 12;
    localparam int RAM_AW     = 7;
    localparam int BANK_W     = 6;
    localparam int ADDR_W     = 13;
    localparam int INDEX_W    = 18;

    // input item kinds
    localparam logic OP_BUS  = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // cartridge decode
    localparam int              CART_BIT      = 12;
    localparam logic [11:0]     HOTSPOT_LO    = 12'hf80;
    localparam logic [11:0]     HOTSPOT_HI    = 12'hfbf;
    localparam logic [11:0]     RAM_WRITE_END = 12'h080;
    localparam logic [11:0]     RAM_READ_END  = 12'h100;
    localparam logic [12:0]     SWCHA_ADDR    = 13'h280;

    // register map
    localparam logic [1:0]      REG_SUPERCHIP = 2'd0;
    localparam logic [1:0]      REG_STARTUP   = 2'd1;
    localparam logic [1:0]      REG_EXIT_ADDR = 2'd2;

    localparam logic [5:0]      STARTUP_BANK_RST = 6'd1;
    localparam logic [12:0]     EXIT_ADDR_RST    = 13'd642;

    // what the lookup stage hands to the result register
    typedef struct packed {
        logic drive;
        logic use_ram;
        logic exit_req;
    } s1_ctrl_t;

endpackage

`default_nettype wire

// ===== src/cartridge_bank_switch_mapper.sv =====
// bank-switching cartridge mapper with optional superchip ram
//
// One item is accepted per clock, back to back, unless the output stalls. The accept
// edge updates the bank, fire flag and memories and starts the registered ROM and
// RAM reads; the result register loads from them when the lookup stage advances.
// A stalled result holds the lookup stage; no further item is taken behind it.
// ROM bytes are loaded through the stream itself (tuser = 1). A hotspot access
// selects its bank before the ROM is read. Writing startup_bank also loads the bank.
`default_nettype none

module cartridge_bank_switch_mapper #(
    parameter int NUM_BANKS = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    // stream in
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // address[12:0], bus_data[20:13], load_index[38:21], load_byte[46:39], zero[47]
    input  wire logic [47:0] s_axis_tdata,
    // operation[0]
    input  wire logic        s_axis_tuser,

    // stream out
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // drive_enable[0], read_data[8:1], exit_request[9], zero[15:10]
    output logic [15:0]      m_axis_tdata,

    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    import cbsm_pkg::*;

    localparam int BANK_AW   = $clog2(NUM_BANKS);
    localparam int ROM_AW    = BANK_AW + OFFSET_W;
    localparam int ROM_DEPTH = NUM_BANKS * BANK_BYTES;

    // input fields
    logic                 in_op;
    logic [ADDR_W-1:0]    in_addr;
    logic [7:0]           in_data;
    logic [INDEX_W-1:0]   in_index;
    logic [7:0]           in_byte;

    assign in_op    = s_axis_tuser;
    assign in_addr  = s_axis_tdata[12:0];
    assign in_data  = s_axis_tdata[20:13];
    assign in_index = s_axis_tdata[38:21];
    assign in_byte  = s_axis_tdata[46:39];

    // configuration registers
    logic                 superchip_reg;
    logic [BANK_W-1:0]    startup_bank_reg;
    logic [ADDR_W-1:0]    exit_addr_reg;
    logic                 cfg_wr;
    logic [1:0]           cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (cfg_idx)
            REG_SUPERCHIP: prdata = {31'd0, superchip_reg};
            REG_STARTUP:   prdata = {26'd0, startup_bank_reg};
            REG_EXIT_ADDR: prdata = {19'd0, exit_addr_reg};
            default:       prdata = 32'd0;
        endcase
    end

    // pipeline control
    logic       accept;
    logic       s1_valid_reg;
    logic       s1_advance;
    s1_ctrl_t   s1_ctrl_reg;
    s1_ctrl_t   s1_ctrl_next;
    logic       out_valid_reg;
    logic       out_drive_reg;
    logic [7:0] out_rdata_reg;
    logic       out_exit_reg;

    assign s1_advance    = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // decode of one item
    logic                 is_bus;
    logic                 is_cart;
    logic [OFFSET_W-1:0]  offset;
    logic                 hotspot;
    logic                 ram_wr_zone;
    logic                 ram_rd_zone;
    logic                 exit_hit;
    logic                 swcha_hit;
    logic                 load_in_range;
    logic [BANK_W-1:0]    bank_reg;
    logic [BANK_W-1:0]    bank_next;
    logic [BANK_W-1:0]    bank_eff;
    logic                 fire_reg;
    logic                 fire_next;
    logic [BANK_AW-1:0]   bank_mod_tbl [64];

    // bank number folded into the fitted ROM
    for (genvar g = 0; g < 64; g++)
    begin : g_bank_mod
        assign bank_mod_tbl[g] = BANK_AW'(g % NUM_BANKS);
    end

    assign is_bus      = (in_op == OP_BUS);
    assign is_cart     = in_addr[CART_BIT];
    assign offset      = in_addr[OFFSET_W-1:0];
    assign hotspot     = (offset >= HOTSPOT_LO) && (offset <= HOTSPOT_HI);
    assign ram_wr_zone = superchip_reg && (offset < RAM_WRITE_END);
    assign ram_rd_zone = superchip_reg && (offset < RAM_READ_END);
    assign exit_hit    = (in_addr == exit_addr_reg);
    assign swcha_hit   = (in_addr == SWCHA_ADDR);
    assign load_in_range = ({1'b0, in_index} < (INDEX_W + 1)'(ROM_DEPTH));
    assign bank_eff    = (is_cart && hotspot) ? BANK_W'(offset - HOTSPOT_LO) : bank_reg;

    always_comb
    begin
        bank_next    = bank_reg;
        fire_next    = fire_reg;
        s1_ctrl_next = '0;
        if (accept && is_bus)
        begin
            if (is_cart)
            begin
                if (!ram_wr_zone)
                begin
                    bank_next            = bank_eff;
                    s1_ctrl_next.drive   = 1'b1;
                    s1_ctrl_next.use_ram = ram_rd_zone;
                end
            end
            else if (exit_hit)
            begin
                s1_ctrl_next.exit_req = !in_data[0] && fire_reg;
            end
            else if (swcha_hit)
            begin
                fire_next = !in_data[7];
            end
        end
        // config writes must happen only while idle; the block itself does not enforce it
        if (cfg_wr && (cfg_idx == REG_STARTUP))
        begin
            bank_next = pwdata[BANK_W-1:0];
        end
    end

    // memories
    logic [7:0]        rom_mem [ROM_DEPTH];
    logic [7:0]        ram_mem [RAM_BYTES];
    logic [7:0]        rom_q_reg;
    logic [7:0]        ram_q_reg;
    logic              rom_we;
    logic              ram_we;
    logic [ROM_AW-1:0] rom_raddr;

    assign rom_we    = accept && !is_bus && load_in_range;
    assign ram_we    = accept && is_bus && is_cart && ram_wr_zone;
    assign rom_raddr = {bank_mod_tbl[bank_eff], offset};

    always_ff @(posedge clk)
    begin
        if (rom_we)
        begin
            rom_mem[in_index[ROM_AW-1:0]] <= in_byte;
        end
        if (accept)
        begin
            rom_q_reg <= rom_mem[rom_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_we)
        begin
            ram_mem[offset[RAM_AW-1:0]] <= in_data;
        end
        if (accept)
        begin
            ram_q_reg <= ram_mem[offset[RAM_AW-1:0]];
        end
    end

    // state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            superchip_reg    <= 1'b0;
            startup_bank_reg <= STARTUP_BANK_RST;
            exit_addr_reg    <= EXIT_ADDR_RST;
            bank_reg         <= STARTUP_BANK_RST;
            fire_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_wr && (cfg_idx == REG_SUPERCHIP))
            begin
                superchip_reg <= pwdata[0];
            end
            if (cfg_wr && (cfg_idx == REG_STARTUP))
            begin
                startup_bank_reg <= pwdata[BANK_W-1:0];
            end
            if (cfg_wr && (cfg_idx == REG_EXIT_ADDR))
            begin
                exit_addr_reg <= pwdata[ADDR_W-1:0];
            end
            bank_reg <= bank_next;
            fire_reg <= fire_next;
        end
    end

    // lookup stage and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ctrl_reg <= s1_ctrl_next;
        end
        if (s1_advance)
        begin
            out_drive_reg <= s1_ctrl_reg.drive;
            out_exit_reg  <= s1_ctrl_reg.exit_req;
            if (!s1_ctrl_reg.drive)
            begin
                out_rdata_reg <= 8'd0;
            end
            else if (s1_ctrl_reg.use_ram)
            begin
                out_rdata_reg <= ram_q_reg;
            end
            else
            begin
                out_rdata_reg <= rom_q_reg;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_exit_reg, out_rdata_reg, out_drive_reg};

    // checks
    a_no_drive_and_exit: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[9]))
        else $error("drive and exit in one result");

    a_idle_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[8:1] == 8'd0))
        else $error("read data not zero without drive");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> s_axis_tready)
        else $error("input stalled with empty lookup stage");

    a_hotspot_bank: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_bus && is_cart && hotspot && !cfg_wr)
        |=> (bank_reg == $past(in_addr[BANK_W-1:0])))
        else $error("hotspot did not select bank");

    a_ram_write_no_drive: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> !s1_ctrl_reg.drive)
        else $error("ram write drives the bus");

endmodule

`default_nettype wire
